// ===== src/sfr_pkg.sv =====
// Constants and types shared by the status frame receiver and its checker.
package sfr_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hBB;
  localparam logic [7:0] LEN_A     = 8'h37;
  localparam logic [7:0] LEN_B     = 8'h3B;
  localparam logic [7:0] LEN_C     = 8'h3E;
  localparam logic [6:0] LEN_INDEX = 7'd4;
  localparam logic [6:0] LEN_EXTRA = 7'd6;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_GOOD   = 2'd1;
  localparam logic [1:0] ST_BADSUM = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [6:0] byte_index;
    logic       frame_end;
    logic [1:0] frame_status;
  } result_t;

endpackage

// ===== src/status_frame_receiver.sv =====
// Status frame receiver: byte framer with length check and XOR checksum.
//
// Takes one received byte per cycle and hunts for the header byte 0xBB; other
// bytes seen while hunting are dropped without a result. A frame is 61, 65 or
// 68 bytes, set by the length code at index 4 (0x37, 0x3B, 0x3E). Each frame
// byte is registered and comes out with its index; the last byte carries
// frame_end and a status of good or bad checksum (the XOR of all earlier frame
// bytes), and an unknown length code ends the frame at once with bad-length
// status. Throughput is one word per cycle while in_stall is low: the framing
// state is updated in the cycle a word is taken, and a two-entry output stage
// (result register plus skid register) lets a word in while a result waits.
// in_stall rises only while the skid register holds a word.
module status_frame_receiver
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [6:0] out_byte_index,
  output logic       out_frame_end,
  output logic [1:0] out_frame_status
);

  logic [1:0] phase_r, phase_nxt;
  logic [6:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [6:0] total_r, total_nxt;

  result_t    res;
  logic       res_valid;
  result_t    out_r, skid_r;
  logic       out_valid_r, skid_valid_r;
  logic       in_take, out_take;
  logic [7:0] next_idx;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign next_idx = {1'b0, count_r} + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    total_nxt = total_r;
    res_valid = 1'b0;
    res.frame_byte   = in_rx_byte;
    res.byte_index   = count_r;
    res.frame_end    = 1'b0;
    res.frame_status = ST_BUSY;
    case (phase_r)
      PH_HEAD: begin
        res_valid = 1'b1;
        if (count_r == LEN_INDEX && in_rx_byte != LEN_A && in_rx_byte != LEN_B
            && in_rx_byte != LEN_C) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_BADLEN;
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          xor_nxt   = '0;
          total_nxt = '0;
        end else begin
          if (count_r == LEN_INDEX) begin
            total_nxt = in_rx_byte[6:0] + LEN_EXTRA;
            phase_nxt = PH_BODY;
          end
          xor_nxt   = xor_r ^ in_rx_byte;
          count_nxt = next_idx[6:0];
        end
      end
      PH_BODY: begin
        res_valid = 1'b1;
        if (next_idx >= {1'b0, total_r}) begin
          res.frame_end    = 1'b1;
          res.frame_status = (in_rx_byte == xor_r) ? ST_GOOD : ST_BADSUM;
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          xor_nxt   = '0;
          total_nxt = '0;
        end else begin
          xor_nxt   = xor_r ^ in_rx_byte;
          count_nxt = next_idx[6:0];
        end
      end
      default: begin
        if (in_rx_byte == HDR_BYTE) begin
          res_valid = 1'b1;
          res.byte_index = '0;
          phase_nxt = PH_HEAD;
          count_nxt = 7'd1;
          xor_nxt   = in_rx_byte;
          total_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      xor_r   <= '0;
      total_r <= '0;
    end else if (in_take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      total_r <= total_nxt;
    end
  end

  // hold a result in skid when the result register is full and stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take && res_valid) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_r.frame_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_end    = out_r.frame_end;
  assign out_frame_status = out_r.frame_status;

endmodule

// ===== src/sfr_checker.sv =====
// Port-level assertions for the status frame receiver, with bind.
module sfr_checker
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic [6:0] out_byte_index,
  input logic       out_frame_end,
  input logic [1:0] out_frame_status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte)
      && $stable(out_byte_index) && $stable(out_frame_status))
    else $error("stalled word changed");

  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_end == (out_frame_status != ST_BUSY))
    else $error("frame_end and status disagree");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == 7'd0 |-> out_frame_byte == HDR_BYTE)
    else $error("index zero is not a header byte");

  a_badlen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_BADLEN |-> out_byte_index == LEN_INDEX)
    else $error("bad length away from length field");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == ST_GOOD || out_frame_status == ST_BADSUM)
      |-> (out_byte_index == 7'd60 || out_byte_index == 7'd64
        || out_byte_index == 7'd67))
    else $error("frame ended at wrong index");

endmodule

bind status_frame_receiver sfr_checker u_sfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_byte   (out_frame_byte),
  .out_byte_index   (out_byte_index),
  .out_frame_end    (out_frame_end),
  .out_frame_status (out_frame_status)
);
